@@ rtl/core/rbei_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rbei_pkg
// Shared types and constants of the random bit error injector: register
// indexes, generator constants, field widths and the sequencer states.
// ---------------------------------------------------------------------------
package rbei_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED     = 2'd1;

  localparam int THRESH_W = 17;
  localparam int SEED_W   = 32;
  localparam int DRAW_W   = 15;
  localparam int SPARE_CNT_W = 4;
  localparam int FLIPS_W  = 7;
  localparam int TOTAL_W  = 32;

  localparam logic [SPARE_CNT_W-1:0] DRAW_BITS = 4'd15;
  localparam logic [SEED_W-1:0] LCG_MUL   = 32'd214013;
  localparam logic [SEED_W-1:0] LCG_ADD   = 32'd2531011;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_REFILL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/random_bit_error_injector.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// random_bit_error_injector
// Flips each bit of a data word, most significant first, when a 16-bit
// pseudo-random value falls below the error threshold. One bit is decided
// per generator step, except when the spare bits are refilled; the word rotates through a shift register.
// ---------------------------------------------------------------------------
// generator use: one generator step per bit decision plus one spare refill
//   step every 15 bits, so 4 or 5 spare refills per word at eight bytes
// threshold zero: the word passes unchanged, nothing drawn
// words: one word at a time; the done state holds while the result register is
//   full and not taken; the next word is taken while a result waits there
// reset: synchronous active low; threshold 0, seed and generator state 1,
//   spare bits, spare count and flip total cleared
// ---------------------------------------------------------------------------
module random_bit_error_injector #(
  parameter int WORD_BYTES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [63:0]                     in_data_word,
  input  wire logic [3:0]                      in_byte_count,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [63:0]                          out_corrupted_word,
  output logic [3:0]                           out_byte_count_out,
  output logic [rbei_pkg::FLIPS_W-1:0]         out_flips_in_word,
  output logic [rbei_pkg::TOTAL_W-1:0]         out_flips_total,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rbei_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import rbei_pkg::*;

  localparam int NBITS = WORD_BYTES * 8;
  localparam int CNT_W = $clog2(NBITS + 1);

  state_t state_r, state_nxt;

  logic [THRESH_W-1:0]    thresh_r;
  logic [SEED_W-1:0]      gen_r, gen_nxt;
  logic [DRAW_W-1:0]      spare_r, spare_nxt;
  logic [SPARE_CNT_W-1:0] spare_cnt_r, spare_cnt_nxt;
  logic [DRAW_W-1:0]      hold_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [63:0]            word_r, word_nxt;
  logic [3:0]             count_r;
  logic [FLIPS_W-1:0]     flips_r;
  logic [CNT_W-1:0]       left_r;

  logic [63:0]            o_word_r;
  logic [3:0]             o_count_r;
  logic [FLIPS_W-1:0]     o_flips_r;
  logic [TOTAL_W-1:0]     o_total_r;
  logic                   o_valid_r;

  logic [SEED_W-1:0] lcg;
  logic [DRAW_W-1:0] draw;
  logic              rand_lsb;
  logic [15:0]       rand_val;
  logic              flip;
  logic              decide;
  logic              need_refill;
  logic              accept;
  logic              finish;
  logic              last_bit;

  assign lcg  = gen_r * LCG_MUL + LCG_ADD;
  assign draw = lcg[30:16];
  assign need_refill = (spare_cnt_r == '0);
  assign last_bit = (left_r == CNT_W'(1));
  assign accept = in_valid && in_ready;
  assign finish = (state_r == ST_DONE) && (!o_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (thresh_r == '0) ? ST_DONE : ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (need_refill) begin
          state_nxt = ST_REFILL;
        end else if (last_bit) begin
          state_nxt = ST_DONE;
        end
      end
      ST_REFILL: begin
        state_nxt = last_bit ? ST_DONE : ST_DRAW;
      end
      ST_DONE: begin
        if (!o_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and datapath selection
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    decide        = 1'b0;
    gen_nxt       = gen_r;
    spare_nxt     = spare_r;
    spare_cnt_nxt = spare_cnt_r;
    rand_lsb      = spare_r[0];
    rand_val      = {draw, spare_r[0]};
    unique case (state_r)
      ST_DRAW: begin
        gen_nxt = lcg;
        if (!need_refill) begin
          decide        = 1'b1;
          rand_lsb      = spare_r[0];
          rand_val      = {draw, rand_lsb};
          spare_nxt     = {1'b0, spare_r[DRAW_W-1:1]};
          spare_cnt_nxt = spare_cnt_r - 1'b1;
        end
      end
      ST_REFILL: begin
        gen_nxt       = lcg;
        decide        = 1'b1;
        rand_lsb      = draw[0];
        rand_val      = {hold_r, rand_lsb};
        spare_nxt     = {1'b0, draw[DRAW_W-1:1]};
        spare_cnt_nxt = DRAW_BITS - 1'b1;
      end
      default: begin
      end
    endcase
    flip     = decide && ({1'b0, rand_val} < thresh_r);
    word_nxt = word_r;
    word_nxt[NBITS-1:0] = {word_r[NBITS-2:0], word_r[NBITS-1] ^ flip};
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thresh_r    <= '0;
      gen_r       <= SEED_RESET;
      spare_r     <= '0;
      spare_cnt_r <= '0;
      total_r     <= '0;
      o_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ERROR_THRESHOLD: thresh_r <= cfg_data[THRESH_W-1:0];
          REG_RANDOM_SEED:     gen_r    <= cfg_data;
          default: begin
          end
        endcase
      end else begin
        gen_r <= gen_nxt;
      end
      spare_r     <= spare_nxt;
      spare_cnt_r <= spare_cnt_nxt;
      if (finish) begin
        total_r   <= total_r + TOTAL_W'(flips_r);
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // word path
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r  <= in_data_word;
      count_r <= in_byte_count;
      flips_r <= '0;
      left_r  <= CNT_W'(NBITS);
    end else if (decide) begin
      word_r  <= word_nxt;
      flips_r <= flips_r + FLIPS_W'(flip);
      left_r  <= left_r - 1'b1;
    end
    if (state_r == ST_DRAW) begin
      hold_r <= draw;
    end
    if (finish) begin
      o_word_r  <= word_r;
      o_count_r <= count_r;
      o_flips_r <= flips_r;
      o_total_r <= total_r + TOTAL_W'(flips_r);
    end
  end

  assign out_valid          = o_valid_r;
  assign out_corrupted_word = o_word_r;
  assign out_byte_count_out = o_count_r;
  assign out_flips_in_word  = o_flips_r;
  assign out_flips_total    = o_total_r;

endmodule

`default_nettype wire
